>>> rtl/core/sld_pkg.sv
// shared types, constants and command/status structs for the frame parser
`timescale 1ns / 1ps

package sld_pkg;

  // frame geometry
  localparam int MAX_FRAME_BYTES = 32;
  localparam int FRAME_OVERHEAD  = 4;
  localparam int PAYLOAD_CAP     = (MAX_FRAME_BYTES > FRAME_OVERHEAD) ?
                                   (MAX_FRAME_BYTES - FRAME_OVERHEAD) : 1;
  localparam int MAX_RESULTS     = 28;
  localparam int LEN_LIMIT       = MAX_FRAME_BYTES - FRAME_OVERHEAD;
  localparam int STORE_AW        = (PAYLOAD_CAP > 1) ? $clog2(PAYLOAD_CAP) : 1;

  localparam logic [7:0] START_BYTE = 8'hAA;

  // register map
  localparam logic [0:0] REG_WANT_COMMAND = 1'b0;
  localparam logic [0:0] REG_COPY_LIMIT   = 1'b1;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_EMPTY     = 2'd1,
    KIND_BAD_SUM   = 2'd2,
    KIND_OTHER_CMD = 2'd3
  } kind_t;

  // running checksum updates
  typedef enum logic [2:0] {
    SUM_HOLD   = 3'd0,
    SUM_START  = 3'd1,
    SUM_ADD    = 3'd2,
    SUM_RESCAN = 3'd3,
    SUM_CLEAR  = 3'd4
  } sum_op_t;

  // parser states
  typedef enum logic [6:0] {
    ST_HUNT = 7'b0000001,
    ST_CMD  = 7'b0000010,
    ST_LEN  = 7'b0000100,
    ST_DATA = 7'b0001000,
    ST_SUM  = 7'b0010000,
    ST_RD   = 7'b0100000,
    ST_WR   = 7'b1000000
  } state_t;

  // controller to datapath
  typedef struct packed {
    sum_op_t sum_op;
    logic    load_cmd;
    logic    load_len;
    logic    store_byte;
    logic    clear;
    logic    run_init;
    logic    rd_issue;
    logic    run_adv;
    logic    out_load;
    kind_t   out_kind;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic byte_start;
    logic len_big;
    logic len_zero;
    logic held_start;
    logic data_done;
    logic sum_ok;
    logic cmd_match;
    logic run_empty;
    logic run_last;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/core/start_length_checksum_deframer.sv
// top level: configuration registers, parser controller and datapath
// a status result is registered and valid in the cycle after its checksum beat is taken
// throughput: one received beat per cycle through header and payload, and through the
//   checksum while the result slot is free; a payload run alternates store reads and
//   result loads, and no beat is taken during the run
// reset (synchronous): parser back to hunting, want_command = 1, copy_limit = 28
`timescale 1ns / 1ps

module start_length_checksum_deframer (
  input  logic        clk,
  input  logic        rst,
  // receive channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        restart,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic [4:0]  byte_index,
  output logic        last,
  output logic [7:0]  command,
  output logic [4:0]  frame_length,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]    want_command;
  logic [4:0]    copy_limit;
  logic          cfg_wr;
  sld_pkg::cmd_t cmd;
  sld_pkg::sts_t sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      want_command <= 8'd1;
      copy_limit   <= 5'd28;
    end else if (cfg_wr) begin
      case (paddr[2])
        sld_pkg::REG_WANT_COMMAND: want_command <= pwdata[7:0];
        sld_pkg::REG_COPY_LIMIT:   copy_limit   <= pwdata[4:0];
        default:                   ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[2])
      sld_pkg::REG_WANT_COMMAND: prdata = {24'd0, want_command};
      sld_pkg::REG_COPY_LIMIT:   prdata = {27'd0, copy_limit};
      default:                   prdata = 32'd0;
    endcase
  end

  sld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .restart  (restart),
    .sts      (sts),
    .cmd      (cmd)
  );

  sld_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .rx_byte      (rx_byte),
    .want_command (want_command),
    .copy_limit   (copy_limit),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .kind         (kind),
    .data_byte    (data_byte),
    .byte_index   (byte_index),
    .last         (last),
    .command      (command),
    .frame_length (frame_length)
  );

endmodule

>>> rtl/core/sld_dpath.sv
// datapath: header registers, checksum, payload store and result register
`timescale 1ns / 1ps

module sld_dpath (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          want_command,
  input  logic [4:0]          copy_limit,
  input  sld_pkg::cmd_t       cmd,
  output sld_pkg::sts_t       sts,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [1:0]          kind,
  output logic [7:0]          data_byte,
  output logic [4:0]          byte_index,
  output logic                last,
  output logic [7:0]          command,
  output logic [4:0]          frame_length
);

  logic [7:0] held_command;
  logic [4:0] held_length;
  logic [4:0] payload_count;
  logic [7:0] running_sum;
  logic [4:0] run_idx;
  logic [7:0] mem_q;
  logic [7:0] payload_store [sld_pkg::PAYLOAD_CAP];

  logic [5:0] count_inc;
  logic [4:0] run_n;
  logic [5:0] idx_inc;

  // run length: min of length, copy limit, the result cap and the store size
  always_comb begin
    run_n = held_length;
    if (run_n > copy_limit) run_n = copy_limit;
    if (run_n > 5'(sld_pkg::MAX_RESULTS)) run_n = 5'(sld_pkg::MAX_RESULTS);
    if (run_n > 5'(sld_pkg::PAYLOAD_CAP)) run_n = 5'(sld_pkg::PAYLOAD_CAP);
  end

  assign count_inc = {1'b0, payload_count} + 6'd1;
  assign idx_inc   = {1'b0, run_idx} + 6'd1;

  // status toward the controller
  always_comb begin
    sts.byte_start = (rx_byte == sld_pkg::START_BYTE);
    sts.len_big    = ({1'b0, rx_byte} > 9'(sld_pkg::LEN_LIMIT));
    sts.len_zero   = (rx_byte == 8'd0);
    sts.held_start = (held_command == sld_pkg::START_BYTE);
    sts.data_done  = (count_inc >= {1'b0, held_length});
    sts.sum_ok     = (running_sum == rx_byte);
    sts.cmd_match  = (held_command == want_command);
    sts.run_empty  = (run_n == 5'd0);
    sts.run_last   = (idx_inc == {1'b0, run_n});
    sts.out_free   = !out_valid || out_ready;
  end

  // header registers and payload counter
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      held_command  <= 8'd0;
      held_length   <= 5'd0;
      payload_count <= 5'd0;
    end else begin
      if (cmd.load_cmd) begin
        held_command <= rx_byte;
      end
      if (cmd.load_len) begin
        held_length   <= rx_byte[4:0];
        payload_count <= 5'd0;
      end else if (cmd.store_byte) begin
        payload_count <= count_inc[4:0];
      end
    end
  end

  // running checksum
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= 8'd0;
    end else begin
      case (cmd.sum_op)
        sld_pkg::SUM_HOLD:   running_sum <= running_sum;
        sld_pkg::SUM_START:  running_sum <= sld_pkg::START_BYTE;
        sld_pkg::SUM_ADD:    running_sum <= running_sum + rx_byte;
        sld_pkg::SUM_RESCAN: running_sum <= sld_pkg::START_BYTE + rx_byte;
        sld_pkg::SUM_CLEAR:  running_sum <= 8'd0;
        default:             running_sum <= running_sum;
      endcase
    end
  end

  // payload store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.store_byte) begin
      payload_store[payload_count[sld_pkg::STORE_AW-1:0]] <= rx_byte;
    end
    if (cmd.rd_issue) begin
      mem_q <= payload_store[run_idx[sld_pkg::STORE_AW-1:0]];
    end
  end

  // run index
  always_ff @(posedge clk) begin
    if (rst) begin
      run_idx <= 5'd0;
    end else if (cmd.run_init) begin
      run_idx <= 5'd0;
    end else if (cmd.run_adv) begin
      run_idx <= idx_inc[4:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kind         <= cmd.out_kind;
      command      <= held_command;
      frame_length <= held_length;
      if (cmd.out_kind == sld_pkg::KIND_BYTE) begin
        data_byte  <= mem_q;
        byte_index <= run_idx;
        last       <= sts.run_last;
      end else begin
        data_byte  <= 8'd0;
        byte_index <= 5'd0;
        last       <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/sld_ctrl.sv
// controller: frame parsing state machine and input handshake
`timescale 1ns / 1ps

module sld_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          restart,
  input  sld_pkg::sts_t sts,
  output sld_pkg::cmd_t cmd
);

  sld_pkg::state_t state;
  sld_pkg::state_t state_next;
  logic            accept;

  // hunting, header and payload beats always go in, the checksum beat needs a free result slot
  always_comb begin
    case (state)
      sld_pkg::ST_HUNT, sld_pkg::ST_CMD, sld_pkg::ST_LEN, sld_pkg::ST_DATA:
        in_ready = 1'b1;
      sld_pkg::ST_SUM:
        in_ready = sts.out_free;
      default:
        in_ready = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  // next state and datapath commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.sum_op     = sld_pkg::SUM_HOLD;
    cmd.out_kind   = sld_pkg::KIND_BYTE;
    if (accept && restart) begin
      cmd.clear  = 1'b1;
      cmd.sum_op = sld_pkg::SUM_CLEAR;
      state_next = sld_pkg::ST_HUNT;
    end else begin
      case (state)
        sld_pkg::ST_HUNT: begin
          if (accept && sts.byte_start) begin
            cmd.sum_op = sld_pkg::SUM_START;
            state_next = sld_pkg::ST_CMD;
          end
        end
        sld_pkg::ST_CMD: begin
          if (accept) begin
            cmd.load_cmd = 1'b1;
            cmd.sum_op   = sld_pkg::SUM_ADD;
            state_next   = sld_pkg::ST_LEN;
          end
        end
        sld_pkg::ST_LEN: begin
          if (accept) begin
            if (sts.len_big) begin
              // drop the start byte and rescan the held bytes
              if (sts.held_start) begin
                cmd.load_cmd = 1'b1;
                cmd.sum_op   = sld_pkg::SUM_RESCAN;
                state_next   = sld_pkg::ST_LEN;
              end else if (sts.byte_start) begin
                cmd.sum_op = sld_pkg::SUM_START;
                state_next = sld_pkg::ST_CMD;
              end else begin
                cmd.clear  = 1'b1;
                cmd.sum_op = sld_pkg::SUM_CLEAR;
                state_next = sld_pkg::ST_HUNT;
              end
            end else begin
              cmd.load_len = 1'b1;
              cmd.sum_op   = sld_pkg::SUM_ADD;
              state_next   = sts.len_zero ? sld_pkg::ST_SUM : sld_pkg::ST_DATA;
            end
          end
        end
        sld_pkg::ST_DATA: begin
          if (accept) begin
            cmd.store_byte = 1'b1;
            cmd.sum_op     = sld_pkg::SUM_ADD;
            if (sts.data_done) begin
              state_next = sld_pkg::ST_SUM;
            end
          end
        end
        sld_pkg::ST_SUM: begin
          if (accept) begin
            if (!sts.sum_ok || !sts.cmd_match || sts.run_empty) begin
              // single status result, frame done
              cmd.out_load = 1'b1;
              if (!sts.sum_ok) begin
                cmd.out_kind = sld_pkg::KIND_BAD_SUM;
              end else if (!sts.cmd_match) begin
                cmd.out_kind = sld_pkg::KIND_OTHER_CMD;
              end else begin
                cmd.out_kind = sld_pkg::KIND_EMPTY;
              end
              cmd.clear  = 1'b1;
              cmd.sum_op = sld_pkg::SUM_CLEAR;
              state_next = sld_pkg::ST_HUNT;
            end else begin
              cmd.run_init = 1'b1;
              state_next   = sld_pkg::ST_RD;
            end
          end
        end
        sld_pkg::ST_RD: begin
          cmd.rd_issue = 1'b1;
          state_next   = sld_pkg::ST_WR;
        end
        sld_pkg::ST_WR: begin
          // hand one payload byte to the result register
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = sld_pkg::KIND_BYTE;
            cmd.run_adv  = 1'b1;
            if (sts.run_last) begin
              cmd.clear  = 1'b1;
              cmd.sum_op = sld_pkg::SUM_CLEAR;
              state_next = sld_pkg::ST_HUNT;
            end else begin
              state_next = sld_pkg::ST_RD;
            end
          end
        end
        default: begin
          state_next = sld_pkg::ST_HUNT;
        end
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sld_pkg::ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> tb/sv/tb_top.sv
// testbench for the start/length/checksum frame parser: directed table, random frames, scoreboard
`timescale 1ns / 1ps

module tb_top;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 64;
  localparam int NUM_PHASES    = 6;
  localparam int PHASE_BEATS   = 76;
  localparam int NUM_ROWS      = 26;
  localparam logic [2:0] WANT_ADDR = {sld_pkg::REG_WANT_COMMAND, 2'b00};
  localparam logic [2:0] COPY_ADDR = {sld_pkg::REG_COPY_LIMIT, 2'b00};

  typedef enum logic [4:0] {
    SEEK_START = 5'b00001,
    GET_CMD    = 5'b00010,
    GET_LEN    = 5'b00100,
    GET_DATA   = 5'b01000,
    GET_SUM    = 5'b10000
  } parse_phase_t;

  typedef struct packed {
    sld_pkg::kind_t kind;
    logic [7:0]     data;
    logic [4:0]     idx;
    logic           last;
    logic [7:0]     cmd;
    logic [4:0]     len;
  } frame_result_t;

  typedef struct packed {
    logic [7:0]     b;
    logic           flush;
    logic           typed;
    sld_pkg::kind_t kind;
    logic [7:0]     cmd;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [4:0]  byte_index;
  logic        last;
  logic [7:0]  command;
  logic [4:0]  frame_length;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // typed expectation riding along with the current beat
  logic          beat_typed = 1'b0;
  frame_result_t beat_typed_res = '0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int beats_sent = 0;
  int errors = 0;
  int idle_cycles = 0;

  // predictor state and configuration mirror
  logic [7:0]   cfg_want = 8'd1;
  logic [4:0]   cfg_limit = 5'd28;
  parse_phase_t cur_phase = SEEK_START;
  logic [7:0]   cur_cmd = 8'd0;
  logic [4:0]   cur_len = 5'd0;
  int           cur_count = 0;
  logic [7:0]   cur_sum = 8'd0;
  logic [7:0]   frame_bytes [sld_pkg::PAYLOAD_CAP];

  frame_result_t expected_results [$];

  // directed rows: hunting drop, empty frame, bad sum, rescans, short run, restart
  dir_row_t directed_rows [NUM_ROWS] = '{
    '{8'h00, 1'b0, 1'b0, sld_pkg::KIND_BYTE, 8'h00},
    '{8'hAA, 1'b0, 1'b0, sld_pkg::KIND_BYTE, 8'h00},
    '{8'h01, 1'b0, 1'b0, sld_pkg::KIND_BYTE, 8'h00},
    '{8'h00, 1'b0, 1'b0, sld_pkg::KIND_BYTE, 8'h00},
    '{8'hAB, 1'b0, 1'b1, sld_pkg::KIND_EMPTY, 8'h01},
    '{8'hAA, 1'b0, 1'b0, sld_pkg::KIND_BYTE, 8'h00},
    '{8'h05, 1'b0, 1'b0, sld_pkg::KIND_BYTE, 8'h00},
    '{8'h00, 1'b0, 1'b0, sld_pkg::KIND_BYTE, 8'h00},
    '{8'h00, 1'b0, 1'b1, sld_pkg::KIND_BAD_SUM, 8'h05},
    '{8'hAA, 1'b0, 1'b0, sld_pkg::KIND_BYTE, 8'h00},
    '{8'hAA, 1'b0, 1'b0, sld_pkg::KIND_BYTE, 8'h00},
    '{8'h1D, 1'b0, 1'b0, sld_pkg::KIND_BYTE, 8'h00},
    '{8'h00, 1'b0, 1'b0, sld_pkg::KIND_BYTE, 8'h00},
    '{8'hC7, 1'b0, 1'b1, sld_pkg::KIND_OTHER_CMD, 8'h1D},
    '{8'hAA, 1'b0, 1'b0, sld_pkg::KIND_BYTE, 8'h00},
    '{8'h07, 1'b0, 1'b0, sld_pkg::KIND_BYTE, 8'h00},
    '{8'hAA, 1'b0, 1'b0, sld_pkg::KIND_BYTE, 8'h00},
    '{8'h01, 1'b0, 1'b0, sld_pkg::KIND_BYTE, 8'h00},
    '{8'h01, 1'b0, 1'b0, sld_pkg::KIND_BYTE, 8'h00},
    '{8'hFF, 1'b0, 1'b0, sld_pkg::KIND_BYTE, 8'h00},
    '{8'hAB, 1'b0, 1'b0, sld_pkg::KIND_BYTE, 8'h00},
    '{8'hAA, 1'b0, 1'b0, sld_pkg::KIND_BYTE, 8'h00},
    '{8'h03, 1'b0, 1'b0, sld_pkg::KIND_BYTE, 8'h00},
    '{8'hFF, 1'b0, 1'b0, sld_pkg::KIND_BYTE, 8'h00},
    '{8'hAA, 1'b0, 1'b0, sld_pkg::KIND_BYTE, 8'h00},
    '{8'hFF, 1'b1, 1'b0, sld_pkg::KIND_BYTE, 8'h00}
  };

  // per-phase settings; a negative entry means a random value
  int phase_want  [NUM_PHASES] = '{255, 0, 170, -1, 1, -1};
  int phase_limit [NUM_PHASES] = '{28, 0, 1, -1, 5, -1};
  int phase_sidle [NUM_PHASES] = '{0, 55, 0, 24, 55, 0};
  int phase_stall [NUM_PHASES] = '{0, 0, 55, 24, 0, 55};

  start_length_checksum_deframer DUT (.*);

  always #10 clk = ~clk;

  // parser state back to hunting
  task automatic clear_frame();
    cur_phase = SEEK_START;
    cur_cmd   = 8'd0;
    cur_len   = 5'd0;
    cur_count = 0;
    cur_sum   = 8'd0;
  endtask

  function automatic void push_result(sld_pkg::kind_t k, logic [7:0] d, logic [4:0] i,
                                      logic l);
    frame_result_t r;
    r = '{k, d, i, l, cur_cmd, cur_len};
    expected_results.push_back(r);
  endfunction

  // predictor: advance the frame parser by one beat, queue the results it causes
  task automatic parse_beat(input logic [7:0] b, input logic flush);
    int n;
    if (flush) begin
      clear_frame();
      return;
    end
    case (cur_phase)
      SEEK_START: begin
        if (b == sld_pkg::START_BYTE) begin
          cur_sum   = sld_pkg::START_BYTE;
          cur_phase = GET_CMD;
        end
      end
      GET_CMD: begin
        cur_cmd   = b;
        cur_sum   = cur_sum + b;
        cur_phase = GET_LEN;
      end
      GET_LEN: begin
        if (sld_pkg::FRAME_OVERHEAD + int'(b) > sld_pkg::MAX_FRAME_BYTES) begin
          // implausible length: rescan held bytes for a new start
          if (cur_cmd == sld_pkg::START_BYTE) begin
            cur_cmd = b;
            cur_sum = sld_pkg::START_BYTE + b;
          end else if (b == sld_pkg::START_BYTE) begin
            cur_sum   = sld_pkg::START_BYTE;
            cur_phase = GET_CMD;
          end else begin
            clear_frame();
          end
        end else begin
          cur_len   = b[4:0];
          cur_count = 0;
          cur_sum   = cur_sum + b;
          cur_phase = (b == 8'd0) ? GET_SUM : GET_DATA;
        end
      end
      GET_DATA: begin
        if (cur_count < sld_pkg::PAYLOAD_CAP) frame_bytes[cur_count] = b;
        cur_count++;
        cur_sum = cur_sum + b;
        if (cur_count >= int'(cur_len)) cur_phase = GET_SUM;
      end
      default: begin
        if (cur_sum != b) begin
          push_result(sld_pkg::KIND_BAD_SUM, 8'd0, 5'd0, 1'b1);
        end else if (cur_cmd != cfg_want) begin
          push_result(sld_pkg::KIND_OTHER_CMD, 8'd0, 5'd0, 1'b1);
        end else begin
          n = cur_len;
          if (n > int'(cfg_limit)) n = cfg_limit;
          if (n > sld_pkg::MAX_RESULTS) n = sld_pkg::MAX_RESULTS;
          if (n > sld_pkg::PAYLOAD_CAP) n = sld_pkg::PAYLOAD_CAP;
          if (n == 0) begin
            push_result(sld_pkg::KIND_EMPTY, 8'd0, 5'd0, 1'b1);
          end else begin
            for (int i = 0; i < n; i++)
              push_result(sld_pkg::KIND_BYTE, frame_bytes[i], i[4:0], (i + 1 == n));
          end
        end
        clear_frame();
      end
    endcase
  endtask

  // scoreboard: predict on accepted input beats, compare accepted result beats
  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    int depth;
    if (!rst) begin
      if (in_valid && in_ready) begin
        depth = expected_results.size();
        parse_beat(rx_byte, restart);
        if (beat_typed) begin
          while (expected_results.size() > depth) void'(expected_results.pop_back());
          expected_results.push_back(beat_typed_res);
        end
      end
      if (out_valid && out_ready) begin
        got = '{sld_pkg::kind_t'(kind), data_byte, byte_index, last, command, frame_length};
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result: kind=%0d data=%02h idx=%0d last=%0b cmd=%02h len=%0d",
                   $time, got.kind, got.data, got.idx, got.last, got.cmd, got.len);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t mismatch: expected kind=%0d data=%02h idx=%0d last=%0b cmd=%02h len=%0d",
                     $time, want.kind, want.data, want.idx, want.last, want.cmd, want.len);
            $display("%0t           actual   kind=%0d data=%02h idx=%0d last=%0b cmd=%02h len=%0d",
                     $time, got.kind, got.data, got.idx, got.last, got.cmd, got.len);
            errors++;
          end
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // watchdog on cycles without any accepted beat or configuration access
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t watchdog: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // drive one input beat, with a random sender gap ahead of it
  task automatic push_beat(input logic [7:0] b, input logic flush, input logic typed,
                           input frame_result_t typed_res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    rx_byte        <= b;
    restart        <= flush;
    beat_typed     <= typed;
    beat_typed_res <= typed_res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic push_plain(input logic [7:0] b);
    push_beat(b, 1'b0, 1'b0, '0);
  endtask

  // one random frame: mostly well formed, some with bad sums, odd lengths or cut short
  task automatic drive_random_frame();
    logic [7:0] seq [$];
    logic [7:0] cmd;
    logic [7:0] len;
    logic [7:0] sum;
    logic [7:0] b;
    int pick;
    int cut;
    pick = $urandom_range(0, 99);
    cmd = (pick < 4) ? sld_pkg::START_BYTE :
          (pick < 70) ? cfg_want : 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 4) len = sld_pkg::START_BYTE;
    else if (pick < 10) len = 8'($urandom_range(29, 255));
    else if (pick < 22) len = 8'($urandom_range(17, 28));
    else len = 8'($urandom_range(0, 6));
    seq.push_back(sld_pkg::START_BYTE);
    seq.push_back(cmd);
    seq.push_back(len);
    sum = sld_pkg::START_BYTE + cmd + len;
    if (len <= 8'd28) begin
      for (int i = 0; i < len; i++) begin
        b = 8'($urandom_range(0, 255));
        seq.push_back(b);
        sum = sum + b;
      end
      if ($urandom_range(0, 99) < 15) sum = sum ^ 8'($urandom_range(1, 255));
      seq.push_back(sum);
    end
    cut = ($urandom_range(0, 99) < 6) ? $urandom_range(1, seq.size() - 1) : seq.size();
    for (int i = 0; i < cut; i++) push_plain(seq[i]);
  endtask

  // configuration write: setup cycle then access cycle
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every expected result, then let the block drain
  task automatic await_quiet();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int pick;
    logic [7:0] w;
    logic [4:0] l;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed table with reset configuration
    for (int r = 0; r < NUM_ROWS; r++)
      push_beat(directed_rows[r].b, directed_rows[r].flush, directed_rows[r].typed,
                '{directed_rows[r].kind, 8'd0, 5'd0, 1'b1, directed_rows[r].cmd, 5'd0});
    in_valid <= 1'b0;

    // random phases, each under its own configuration and idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      await_quiet();
      w = (phase_want[p] < 0) ? 8'($urandom_range(0, 255)) : 8'(phase_want[p]);
      l = (phase_limit[p] < 0) ? 5'($urandom_range(0, 28)) : 5'(phase_limit[p]);
      write_reg(WANT_ADDR, {24'd0, w});
      write_reg(COPY_ADDR, {27'd0, l});
      cfg_want      = w;
      cfg_limit     = l;
      send_idle_pct = phase_sidle[p];
      stall_pct     = phase_stall[p];
      beats_sent    = 0;
      while (beats_sent < PHASE_BEATS) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          repeat ($urandom_range(1, 4)) push_plain(8'($urandom_range(0, 255)));
        end else if (pick < 11) begin
          push_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
        end else begin
          drive_random_frame();
        end
      end
      // flush any partial frame before the next register writes
      push_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
      in_valid <= 1'b0;
    end

    await_quiet();
    if (expected_results.size() != 0) begin
      $display("%0t %0d expected results never arrived", $time, expected_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
